// ===== src/union_find_maze_wall_opener_macros.svh =====
// Assertion helpers shared by the maze wall opener RTL.
`ifndef UNION_FIND_MAZE_WALL_OPENER_MACROS_SVH
`define UNION_FIND_MAZE_WALL_OPENER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define UFMWO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UFMWO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ufmwo_pkg.sv =====
package ufmwo_pkg;

  localparam int COL_W  = 5;
  localparam int ROW_W  = 5;
  localparam int GW_W   = 6;
  localparam int RANK_W = 4;
  localparam int WIDX_W = 10;

  localparam logic [GW_W-1:0]   GW_RESET = 6'd32;
  localparam logic [GW_W-1:0]   GW_MIN   = 6'd2;
  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [WIDX_W-1:0] wall_idx_t;

endpackage

// ===== src/union_find_maze_wall_opener.sv =====
// Channel  | Ports                                         | Direction
// ---------+-----------------------------------------------+----------
// in       | in_valid/in_stall, in_cell_col/row/toward_below | into block
// out      | out_valid/out_stall, out_opened/is_horizontal/wall_index | out of block
// cfg      | cfg_valid/cfg_ready, cfg_grid_width           | into block
//
// One transaction at a time. Each wall passes through idle, start, one parent read
// per node up to each root, one write-back per node below each root, union and
// output; a wall that is not interior goes from start straight to output. After
// reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT cells (1024 by default)
// initializes both stores; in_stall stays high then.
// A finished result waits in the output register; the block is free to take the
// next wall as soon as it has handed its result over to that register.
`include "union_find_maze_wall_opener_macros.svh"

module union_find_maze_wall_opener import ufmwo_pkg::*; #(
  parameter int MAX_WIDTH  = 32,
  parameter int MAX_HEIGHT = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [COL_W-1:0]  in_cell_col,
  input  logic [ROW_W-1:0]  in_cell_row,
  input  logic              in_toward_below,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_opened,
  output logic              out_is_horizontal,
  output logic [WIDX_W-1:0] out_wall_index,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [GW_W-1:0]   cfg_grid_width
);

  localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
  localparam int CELL_W     = $clog2(CELL_COUNT);
  localparam int WW_A       = $clog2(MAX_WIDTH + 2);
  localparam int HW_A       = $clog2(MAX_HEIGHT + 2);
  localparam int EXT_B      = (WW_A > HW_A) ? WW_A : HW_A;
  localparam int EXT_W      = (EXT_B > GW_W) ? EXT_B : GW_W;
  localparam int LIN_A      = EXT_W + ROW_W + 1;
  localparam int LIN_W      = (LIN_A > CELL_W + 1) ? LIN_A : CELL_W + 1;

  localparam logic [EXT_W-1:0]  MAXW_C    = EXT_W'(MAX_WIDTH);
  localparam logic [EXT_W-1:0]  MAXH_C    = EXT_W'(MAX_HEIGHT);
  localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELL_COUNT - 1);

  typedef logic [CELL_W-1:0] cell_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_FIND,
    S_COMP,
    S_UNION,
    S_OUT
  } state_t;

  // union-find stores
  cell_t parent_mem [CELL_COUNT];
  rank_t rank_mem   [CELL_COUNT];

  state_t          state_r, state_nxt;
  cell_t           clr_r, clr_nxt;
  logic            side_r, side_nxt;
  cell_t           cur_r, cur_nxt;
  cell_t           cell_a_r, cell_a_nxt;
  cell_t           cell_b_r, cell_b_nxt;
  wall_idx_t       idx_r, idx_nxt;
  logic            below_r, below_nxt;
  logic            legal_r, legal_nxt;
  cell_t           root_a_r, root_a_nxt;
  cell_t           root_b_r, root_b_nxt;
  rank_t           rank_a_r, rank_a_nxt;
  rank_t           rank_b_r, rank_b_nxt;
  logic            opened_r, opened_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_opened_r, out_opened_nxt;
  logic            out_horiz_r, out_horiz_nxt;
  wall_idx_t       out_index_r, out_index_nxt;
  logic [GW_W-1:0] grid_width_r;

  cell_t p_rdata_r;
  rank_t r_rdata_r;

  logic  p_we;
  cell_t p_waddr, p_wdata;
  logic  r_we;
  cell_t r_waddr;
  rank_t r_wdata;

  // wall geometry
  logic [EXT_W-1:0] gw_x, eff_w, col_x, row_x;
  logic [LIN_W-1:0] lin_a, lin_b, lin_v;
  logic             geo_legal;
  cell_t            start_cell, cur_root;

  always_comb begin
    gw_x  = EXT_W'(grid_width_r);
    col_x = EXT_W'(in_cell_col);
    row_x = EXT_W'(in_cell_row);
    if (gw_x < EXT_W'(GW_MIN)) begin
      eff_w = EXT_W'(GW_MIN);
    end else if (gw_x > MAXW_C) begin
      eff_w = MAXW_C;
    end else begin
      eff_w = gw_x;
    end
    geo_legal = (col_x < eff_w) && (row_x < MAXH_C) &&
                (in_toward_below ? (row_x + EXT_W'(1) < MAXH_C)
                                 : (col_x + EXT_W'(1) < eff_w));
    lin_a = LIN_W'(in_cell_row) * LIN_W'(eff_w) + LIN_W'(in_cell_col);
    lin_b = in_toward_below ? lin_a + LIN_W'(eff_w) : lin_a + LIN_W'(1);
    // row*(w-1)+col == row*w+col-row
    lin_v = lin_a - LIN_W'(in_cell_row);
  end

  assign start_cell = side_r ? cell_b_r : cell_a_r;
  assign cur_root   = side_r ? root_b_r : root_a_r;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    side_nxt       = side_r;
    cur_nxt        = cur_r;
    cell_a_nxt     = cell_a_r;
    cell_b_nxt     = cell_b_r;
    idx_nxt        = idx_r;
    below_nxt      = below_r;
    legal_nxt      = legal_r;
    root_a_nxt     = root_a_r;
    root_b_nxt     = root_b_r;
    rank_a_nxt     = rank_a_r;
    rank_b_nxt     = rank_b_r;
    opened_nxt     = opened_r;
    out_valid_nxt  = out_valid_r;
    out_opened_nxt = out_opened_r;
    out_horiz_nxt  = out_horiz_r;
    out_index_nxt  = out_index_r;
    p_we           = 1'b0;
    p_waddr        = cur_r;
    p_wdata        = cur_root;
    r_we           = 1'b0;
    r_waddr        = root_a_r;
    r_wdata        = rank_a_r + rank_t'(1);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr_r;
        p_wdata = clr_r;
        r_we    = 1'b1;
        r_waddr = clr_r;
        r_wdata = '0;
        clr_nxt = clr_r + cell_t'(1);
        if (clr_r == LAST_CELL) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cell_a_nxt = lin_a[CELL_W-1:0];
          cell_b_nxt = lin_b[CELL_W-1:0];
          idx_nxt    = !geo_legal ? '0 :
                       in_toward_below ? lin_a[WIDX_W-1:0] : lin_v[WIDX_W-1:0];
          below_nxt  = in_toward_below;
          legal_nxt  = geo_legal;
          state_nxt  = S_START;
        end
      end
      S_START: begin
        side_nxt   = 1'b0;
        opened_nxt = 1'b0;
        if (legal_r) begin
          cur_nxt   = cell_a_r;
          state_nxt = S_FIND;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_FIND: begin
        // p_rdata_r holds parent of cur_r
        if (p_rdata_r == cur_r) begin
          if (side_r) begin
            root_b_nxt = cur_r;
            rank_b_nxt = r_rdata_r;
          end else begin
            root_a_nxt = cur_r;
            rank_a_nxt = r_rdata_r;
          end
          if (start_cell != cur_r) begin
            cur_nxt   = start_cell;
            state_nxt = S_COMP;
          end else if (!side_r) begin
            side_nxt  = 1'b1;
            cur_nxt   = cell_b_r;
            state_nxt = S_FIND;
          end else begin
            state_nxt = S_UNION;
          end
        end else begin
          cur_nxt = p_rdata_r;
        end
      end
      S_COMP: begin
        p_we = 1'b1;
        if (p_rdata_r != cur_root) begin
          cur_nxt = p_rdata_r;
        end else if (!side_r) begin
          side_nxt  = 1'b1;
          cur_nxt   = cell_b_r;
          state_nxt = S_FIND;
        end else begin
          state_nxt = S_UNION;
        end
      end
      S_UNION: begin
        if (root_a_r != root_b_r) begin
          opened_nxt = 1'b1;
          p_we       = 1'b1;
          if (rank_a_r < rank_b_r) begin
            p_waddr = root_a_r;
            p_wdata = root_b_r;
          end else begin
            p_waddr = root_b_r;
            p_wdata = root_a_r;
            if ((rank_a_r == rank_b_r) && (rank_a_r != RANK_MAX)) begin
              r_we = 1'b1;
            end
          end
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_opened_nxt = opened_r;
          out_horiz_nxt  = below_r;
          out_index_nxt  = idx_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      side_r       <= 1'b0;
      cur_r        <= '0;
      out_valid_r  <= 1'b0;
      grid_width_r <= GW_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      side_r      <= side_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        grid_width_r <= cfg_grid_width;
      end
    end
    cell_a_r     <= cell_a_nxt;
    cell_b_r     <= cell_b_nxt;
    idx_r        <= idx_nxt;
    below_r      <= below_nxt;
    legal_r      <= legal_nxt;
    root_a_r     <= root_a_nxt;
    root_b_r     <= root_b_nxt;
    rank_a_r     <= rank_a_nxt;
    rank_b_r     <= rank_b_nxt;
    opened_r     <= opened_nxt;
    out_opened_r <= out_opened_nxt;
    out_horiz_r  <= out_horiz_nxt;
    out_index_r  <= out_index_nxt;
  end

  // parent store: read at cur_nxt, write-first forwarding on address match
  always_ff @(posedge clk) begin
    if (p_we) begin
      parent_mem[p_waddr] <= p_wdata;
    end
    if (p_we && (p_waddr == cur_nxt)) begin
      p_rdata_r <= p_wdata;
    end else begin
      p_rdata_r <= parent_mem[cur_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      rank_mem[r_waddr] <= r_wdata;
    end
    if (r_we && (r_waddr == cur_nxt)) begin
      r_rdata_r <= r_wdata;
    end else begin
      r_rdata_r <= rank_mem[cur_nxt];
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_opened        = out_opened_r;
  assign out_is_horizontal = out_horiz_r;
  assign out_wall_index    = out_index_r;

  `UFMWO_ASSERT_IMP(a_comp_not_root, state_r == S_COMP, cur_r != cur_root,
    "path compression visiting the root itself")
  `UFMWO_ASSERT_IMP(a_union_distinct, (state_r == S_UNION) && p_we,
    root_a_r != root_b_r, "union of a set with itself")
  `UFMWO_ASSERT_IMP(a_rank_write_src, r_we,
    (state_r == S_CLEAR) || (state_r == S_UNION), "stray rank write")
  `UFMWO_ASSERT_IMP(a_out_from_done, $rose(out_valid_r), $past(state_r) == S_OUT,
    "result presented outside the done state")
  `UFMWO_ASSERT_NXT(a_accept_start, in_valid && !in_stall, state_r == S_START,
    "accepted wall did not start a lookup")

endmodule

// ===== bench/union_find_maze_wall_opener_tb.sv =====
module union_find_maze_wall_opener_tb;
  import ufmwo_pkg::*;

  localparam int MAX_W       = 32;
  localparam int MAX_H       = 32;
  localparam int CELLS       = MAX_W * MAX_H;
  localparam int PHASES      = 8;
  localparam int PHASE_WALLS = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             below;
  } wall_req_t;

  typedef struct packed {
    logic      opened;
    logic      is_horizontal;
    wall_idx_t wall_index;
  } wall_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [COL_W-1:0]  in_cell_col;
  logic [ROW_W-1:0]  in_cell_row;
  logic              in_toward_below;
  logic              out_valid;
  logic              out_stall;
  logic              out_opened;
  logic              out_is_horizontal;
  logic [WIDX_W-1:0] out_wall_index;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [GW_W-1:0]   cfg_grid_width;

  // predictor state
  logic [9:0]      parent_of [CELLS];
  rank_t           rank_of [CELLS];
  logic [GW_W-1:0] grid_width_now;

  wall_req_t    walls_pending[$];
  wall_result_t due_results[$];
  wall_req_t    next_wall;
  wall_result_t got_result;
  wall_result_t due_result;

  logic wall_taken;
  int   send_idle_pct;
  int   stall_pct;
  logic hold_on;
  int   hold_count;
  int   cfg_writes;
  int   error_count;
  int   cycle_count;

  union_find_maze_wall_opener u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cell_col       (in_cell_col),
    .in_cell_row       (in_cell_row),
    .in_toward_below   (in_toward_below),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_opened        (out_opened),
    .out_is_horizontal (out_is_horizontal),
    .out_wall_index    (out_wall_index),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_grid_width    (cfg_grid_width)
  );

  always #2 clk = ~clk;

  function automatic int unsigned eff_width();
    if (grid_width_now < GW_MIN) return GW_MIN;
    if (grid_width_now > MAX_W) return MAX_W;
    return grid_width_now;
  endfunction

  // root lookup; every node on the path is pointed straight at the root
  function automatic int unsigned find_root(int unsigned node);
    int unsigned root;
    int unsigned nxt;
    root = node;
    while (parent_of[root] != root) root = parent_of[root];
    while (node != root) begin
      nxt = parent_of[node];
      parent_of[node] = 10'(root);
      node = nxt;
    end
    return root;
  endfunction

  function automatic wall_result_t open_wall(wall_req_t req);
    int unsigned w, col, row, a, b, ra, rb;
    logic ok;
    wall_result_t res;
    w = eff_width();
    col = req.col;
    row = req.row;
    res.is_horizontal = req.below;
    res.opened = 1'b0;
    res.wall_index = '0;
    ok = (col < w) && (row < MAX_H);
    if (req.below) ok = ok && (row + 1 < MAX_H);
    else ok = ok && (col + 1 < w);
    if (!ok) return res;
    a = row * w + col;
    b = req.below ? (row + 1) * w + col : a + 1;
    res.wall_index = WIDX_W'(req.below ? row * w + col : row * (w - 1) + col);
    ra = find_root(a);
    rb = find_root(b);
    if (ra != rb) begin
      res.opened = 1'b1;
      if (rank_of[ra] < rank_of[rb]) begin
        parent_of[ra] = 10'(rb);
      end else if (rank_of[ra] > rank_of[rb]) begin
        parent_of[rb] = 10'(ra);
      end else begin
        parent_of[rb] = 10'(ra);
        if (rank_of[ra] < RANK_MAX) rank_of[ra] = rank_of[ra] + 1'b1;
      end
    end
    return res;
  endfunction

  // mostly interior walls for the current width, some raw noise
  function automatic wall_req_t random_wall();
    wall_req_t r;
    int unsigned w;
    w = eff_width();
    if ($urandom_range(99) < 15) begin
      r.col = COL_W'($urandom_range(31));
      r.row = ROW_W'($urandom_range(31));
      r.below = 1'($urandom_range(1));
    end else begin
      r.below = 1'($urandom_range(1));
      if (r.below) begin
        r.col = COL_W'($urandom_range(w - 1));
        r.row = ROW_W'($urandom_range(MAX_H - 2));
      end else begin
        r.col = COL_W'($urandom_range(w - 2));
        r.row = ROW_W'($urandom_range(MAX_H - 1));
      end
    end
    return r;
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst_n && (!in_valid || wall_taken)) begin
      if (walls_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_wall = walls_pending.pop_front();
        in_cell_col <= next_wall.col;
        in_cell_row <= next_wall.row;
        in_toward_below <= next_wall.below;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver; the long hold-off lets the block back up into its input
  always @(negedge clk) begin
    if (hold_on && hold_count < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor: config and input transactions feed the predictor, results are checked
  always @(posedge clk) begin
    wall_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        grid_width_now = cfg_grid_width;
        cfg_writes++;
      end
      if (out_valid && !out_stall) begin
        got_result = '{out_opened, out_is_horizontal, out_wall_index};
        if (due_results.size() == 0) begin
          $error("result with none expected: opened %0d horizontal %0d index %0d",
                 out_opened, out_is_horizontal, out_wall_index);
          error_count++;
        end else begin
          due_result = due_results.pop_front();
          if (got_result.opened !== due_result.opened) begin
            $error("opened: expected %0d, got %0d", due_result.opened, got_result.opened);
            error_count++;
          end
          if (got_result.is_horizontal !== due_result.is_horizontal) begin
            $error("is_horizontal: expected %0d, got %0d",
                   due_result.is_horizontal, got_result.is_horizontal);
            error_count++;
          end
          if (got_result.wall_index !== due_result.wall_index) begin
            $error("wall_index: expected %0d, got %0d",
                   due_result.wall_index, got_result.wall_index);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        due_results.push_back(open_wall(wall_req_t'{in_cell_col, in_cell_row, in_toward_below}));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("union_find_maze_wall_opener_tb: done, errors");
      $finish;
    end
  end

  // checked at the rising edge, after the sender has settled
  task automatic drain();
    while (walls_pending.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int unsigned widths [PHASES] = '{2, 0, 63, 7, 32, 1, 33, 19};
    int seen;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cell_col = '0;
    in_cell_row = '0;
    in_toward_below = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_grid_width = '0;
    wall_taken = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_on = 1'b0;
    hold_count = 0;
    cfg_writes = 0;
    error_count = 0;
    cycle_count = 0;
    for (int i = 0; i < CELLS; i++) begin
      parent_of[i] = 10'(i);
      rank_of[i] = '0;
    end
    grid_width_now = GW_RESET;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // corners, last column and row, and a closed square at the reset width
    walls_pending.push_back('{5'd0, 5'd0, 1'b0});
    walls_pending.push_back('{5'd0, 5'd0, 1'b1});
    walls_pending.push_back('{5'd0, 5'd0, 1'b0});
    walls_pending.push_back('{5'd1, 5'd0, 1'b1});
    walls_pending.push_back('{5'd0, 5'd1, 1'b0});
    walls_pending.push_back('{5'd30, 5'd0, 1'b0});
    walls_pending.push_back('{5'd31, 5'd0, 1'b0});
    walls_pending.push_back('{5'd31, 5'd0, 1'b1});
    walls_pending.push_back('{5'd0, 5'd30, 1'b1});
    walls_pending.push_back('{5'd0, 5'd31, 1'b1});
    walls_pending.push_back('{5'd31, 5'd31, 1'b0});
    walls_pending.push_back('{5'd31, 5'd31, 1'b1});
    walls_pending.push_back('{5'd30, 5'd31, 1'b0});
    walls_pending.push_back('{5'd31, 5'd30, 1'b1});
    walls_pending.push_back('{5'd30, 5'd30, 1'b0});
    walls_pending.push_back('{5'd30, 5'd30, 1'b1});
    walls_pending.push_back('{5'd30, 5'd31, 1'b0});
    walls_pending.push_back('{5'd15, 5'd16, 1'b1});
    walls_pending.push_back('{5'd15, 5'd16, 1'b0});
    walls_pending.push_back('{5'd16, 5'd16, 1'b1});
    walls_pending.push_back('{5'd15, 5'd17, 1'b0});
    walls_pending.push_back('{5'd1, 5'd0, 1'b0});
    walls_pending.push_back('{5'd0, 5'd1, 1'b1});

    for (int p = 0; p < PHASES; p++) begin
      drain();
      repeat (4) @(negedge clk);
      seen = cfg_writes;
      cfg_grid_width <= GW_W'(widths[p]);
      cfg_valid <= 1'b1;
      while (cfg_writes == seen) @(negedge clk);
      cfg_valid <= 1'b0;
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 60; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      if (p == 4) hold_on = 1'b1;
      for (int n = 0; n < PHASE_WALLS; n++) walls_pending.push_back(random_wall());
    end

    drain();
    repeat (40) @(negedge clk);
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      error_count++;
    end
    if (error_count == 0) $display("union_find_maze_wall_opener_tb: done, clean");
    else $display("union_find_maze_wall_opener_tb: done, errors");
    $finish;
  end

endmodule
